>>> sv/kpd2_pkg.sv
// shared types, constants and key tables for the two-digit keypad entry unit
`timescale 1ns / 1ps

package kpd2_pkg;

	localparam int ROWS_DEF = 4;
	localparam int COLS_DEF = 3;
	localparam int COL_STRIDE = 3;

	localparam int KEY_W = 4;
	localparam int RC_W = 12;
	localparam int CN_W = 3;
	localparam int CNT_W = 4;
	localparam int VAL_W = 9;
	localparam int WGT_W = 5;

	localparam logic OP_SCAN = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [KEY_W-1:0] KEY_STAR = 4'd10;
	localparam logic [KEY_W-1:0] KEY_HASH = 4'd11;
	localparam logic [KEY_W-1:0] KEY_NONE = 4'd15;

	localparam logic signed [VAL_W-1:0] RESET_VALUE = 9'sd30;

	// bundle handed from cell to cell
	typedef struct packed {
		logic             op;
		logic [RC_W-1:0]  rc;
		logic [CN_W-1:0]  cn;
		logic [CNT_W-1:0] cnt;
		logic [KEY_W-1:0] ka;  // last key seen
		logic [KEY_W-1:0] kb;  // second to last
		logic [KEY_W-1:0] kc;  // third to last
	} cell_bus_t;

	typedef struct packed {
		logic [CNT_W-1:0]        presses;
		logic                    released;
		logic                    awaiting;
		logic [KEY_W-1:0]        held;
		logic signed [VAL_W-1:0] threshold;
	} result_t;

	function automatic logic [KEY_W-1:0] key_code(input int row, input int col);
		logic [KEY_W-1:0] k;
		case (row)
			0: k = KEY_W'(col + 1);
			1: k = KEY_W'(col + 4);
			2: k = KEY_W'(col + 7);
			3: begin
				case (col)
					0: k = KEY_STAR;
					1: k = 4'd0;
					default: k = KEY_HASH;
				endcase
			end
			default: k = KEY_NONE;
		endcase
		return k;
	endfunction

	// star counts as -6, hash as -13, anything unused as zero
	function automatic logic signed [WGT_W-1:0] key_weight(input logic [KEY_W-1:0] k);
		logic signed [WGT_W-1:0] w;
		case (k)
			KEY_STAR: w = -5'sd6;
			KEY_HASH: w = -5'sd13;
			default: w = (k <= 4'd9) ? $signed({1'b0, k}) : 5'sd0;
		endcase
		return w;
	endfunction

endpackage

>>> sv/kpd2_cell.sv
// one key position of the scan chain: counts a press and shifts in its key code
`timescale 1ns / 1ps

module kpd2_cell #(
	parameter int                          BIT = 0,
	parameter logic [kpd2_pkg::KEY_W-1:0] KEY = 4'd1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  kpd2_pkg::cell_bus_t in_bus,
	output logic                out_valid,
	input  logic                out_ready,
	output kpd2_pkg::cell_bus_t out_bus
);

	logic                valid_q;
	kpd2_pkg::cell_bus_t bus_q;
	kpd2_pkg::cell_bus_t bus_nxt;
	logic                hit;

	assign in_ready = !valid_q || out_ready;
	assign hit = (in_bus.op == kpd2_pkg::OP_SCAN) && in_bus.rc[BIT];

	always_comb begin
		bus_nxt = in_bus;
		if (hit) begin
			bus_nxt.kc = in_bus.kb;
			bus_nxt.kb = in_bus.ka;
			bus_nxt.ka = KEY;
			bus_nxt.cnt = in_bus.cnt + kpd2_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			bus_q <= bus_nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_bus = bus_q;

endmodule

>>> sv/kpd2_resolve.sv
// end of chain: applies the collected presses to the pair state and holds the result word
`timescale 1ns / 1ps

module kpd2_resolve (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  kpd2_pkg::cell_bus_t in_bus,
	output logic                out_valid,
	input  logic                out_ready,
	output kpd2_pkg::result_t   out_res
);

	logic                                  rel_q;
	logic                                  phase_q;
	logic [kpd2_pkg::KEY_W-1:0]            first_q;
	logic signed [kpd2_pkg::VAL_W-1:0]     val_q;
	logic                                  out_valid_q;
	kpd2_pkg::result_t                     res_q;

	logic                                  acc;
	logic                                  take;
	logic                                  upd;
	logic [kpd2_pkg::KEY_W-1:0]            hi;
	logic [kpd2_pkg::KEY_W-1:0]            lo;
	logic [kpd2_pkg::KEY_W-1:0]            first_nxt;
	logic signed [kpd2_pkg::WGT_W-1:0]     w_hi;
	logic signed [kpd2_pkg::WGT_W-1:0]     w_lo;
	logic signed [kpd2_pkg::VAL_W-1:0]     hi_ext;
	logic signed [kpd2_pkg::VAL_W-1:0]     lo_ext;
	logic signed [kpd2_pkg::VAL_W-1:0]     pair_val;
	logic                                  rel_nxt;
	logic                                  phase_nxt;
	logic signed [kpd2_pkg::VAL_W-1:0]     val_nxt;

	assign in_ready = !out_valid_q || out_ready;
	assign acc = in_valid && in_ready;
	assign take = (in_bus.op == kpd2_pkg::OP_SCAN) && rel_q && (in_bus.cnt != '0);

	// only the last pair completed in this word and the last key matter
	always_comb begin
		hi = in_bus.kb;
		lo = in_bus.ka;
		upd = 1'b1;
		first_nxt = kpd2_pkg::KEY_NONE;
		if (!phase_q) begin
			if (!in_bus.cnt[0]) begin
				hi = in_bus.kb;
				lo = in_bus.ka;
			end else begin
				first_nxt = in_bus.ka;
				hi = in_bus.kc;
				lo = in_bus.kb;
				upd = (in_bus.cnt >= kpd2_pkg::CNT_W'(3));
			end
		end else begin
			if (in_bus.cnt[0]) begin
				hi = (in_bus.cnt == kpd2_pkg::CNT_W'(1)) ? first_q : in_bus.kb;
				lo = in_bus.ka;
			end else begin
				first_nxt = in_bus.ka;
				hi = (in_bus.cnt == kpd2_pkg::CNT_W'(2)) ? first_q : in_bus.kc;
				lo = in_bus.kb;
			end
		end
	end

	assign w_hi = kpd2_pkg::key_weight(hi);
	assign w_lo = kpd2_pkg::key_weight(lo);
	assign hi_ext = kpd2_pkg::VAL_W'(w_hi);
	assign lo_ext = kpd2_pkg::VAL_W'(w_lo);
	// times ten as eight plus two
	assign pair_val = (hi_ext <<< 3) + (hi_ext <<< 1) + lo_ext;

	always_comb begin
		rel_nxt = rel_q;
		phase_nxt = phase_q;
		val_nxt = val_q;
		if (in_bus.op == kpd2_pkg::OP_SCAN) begin
			if (take) begin
				rel_nxt = 1'b0;
				phase_nxt = phase_q ^ in_bus.cnt[0];
				if (upd) begin
					val_nxt = pair_val;
				end
			end
		end else if (!rel_q && in_bus.cn == '0) begin
			rel_nxt = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_q <= 1'b1;
			phase_q <= 1'b0;
			first_q <= kpd2_pkg::KEY_NONE;
			val_q <= kpd2_pkg::RESET_VALUE;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				out_valid_q <= in_valid;
			end
			if (acc) begin
				rel_q <= rel_nxt;
				phase_q <= phase_nxt;
				val_q <= val_nxt;
				if (take) begin
					first_q <= first_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_q.threshold <= val_nxt;
			res_q.held <= take ? first_nxt : first_q;
			res_q.awaiting <= phase_nxt;
			res_q.released <= rel_nxt;
			res_q.presses <= take ? in_bus.cnt : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res = res_q;

	a_phase_matches_held: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == (first_q != kpd2_pkg::KEY_NONE))
		else $error("pair phase and held key disagree");

	a_presses_clear_release: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.presses != '0) |-> !res_q.released)
		else $error("presses reported while keypad still marked released");

	a_phase_parity: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> phase_q == $past(phase_q ^ (take & in_bus.cnt[0])))
		else $error("pair phase did not follow press parity");

	a_release_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rel_q) |-> $past(acc && in_bus.op == kpd2_pkg::OP_RELEASE))
		else $error("release mark set without a release check");

endmodule

>>> sv/keypad_two_digit_entry_unit.sv
// top level: 4x3 keypad scan chain turning key pairs into a two-digit threshold
//
//  channel  | dir | fields
//  s_*      | in  | tuser: operation; tdata: row_columns, columns_now
//  m_*      | out | tdata: threshold, held_key, awaiting_second, released, presses_taken
//
// one cell per key position, ROWS*COLS cells, then a resolve stage with the state
// a new word is taken every cycle unless the output stalls
// the pair state lives only in the resolve stage, updated once per word
// reset clears all valid bits and sets threshold 30, no key held, keypad released
// a stalled output fills the chain one cell at a time before s_tready drops
`timescale 1ns / 1ps

module keypad_two_digit_entry_unit #(
	parameter int ROWS = kpd2_pkg::ROWS_DEF,
	parameter int COLS = kpd2_pkg::COLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // row_columns[11:0], columns_now[14:12], zero pad
	input  logic        s_tuser,  // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // threshold[8:0], held_key[12:9], awaiting_second[13],
	                              // released[14], presses_taken[18:15], zero pad
);

	localparam int NCELL = ROWS * COLS;

	logic                chain_valid [NCELL+1];
	logic                chain_ready [NCELL+1];
	kpd2_pkg::cell_bus_t chain_bus   [NCELL+1];
	kpd2_pkg::result_t   res;

	always_comb begin
		chain_bus[0].op = s_tuser;
		chain_bus[0].rc = s_tdata[kpd2_pkg::RC_W-1:0];
		chain_bus[0].cn = s_tdata[kpd2_pkg::RC_W +: kpd2_pkg::CN_W];
		chain_bus[0].cnt = '0;
		chain_bus[0].ka = kpd2_pkg::KEY_NONE;
		chain_bus[0].kb = kpd2_pkg::KEY_NONE;
		chain_bus[0].kc = kpd2_pkg::KEY_NONE;
	end

	assign chain_valid[0] = s_tvalid;
	assign s_tready = chain_ready[0];

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		localparam int ROW = g / COLS;
		localparam int COL = g % COLS;
		kpd2_cell #(
			.BIT(ROW * kpd2_pkg::COL_STRIDE + COL),
			.KEY(kpd2_pkg::key_code(ROW, COL))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (chain_valid[g]),
			.in_ready (chain_ready[g]),
			.in_bus   (chain_bus[g]),
			.out_valid(chain_valid[g+1]),
			.out_ready(chain_ready[g+1]),
			.out_bus  (chain_bus[g+1])
		);
	end

	kpd2_resolve u_resolve (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chain_valid[NCELL]),
		.in_ready (chain_ready[NCELL]),
		.in_bus   (chain_bus[NCELL]),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (res)
	);

	assign m_tdata = {5'd0, res.presses, res.released, res.awaiting, res.held,
		res.threshold};

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the two-digit keypad entry unit: directed and random key words
`timescale 1ns / 1ps

module tb_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_WORDS = 950;
	localparam int DRAIN_CYCLES = 40;

	// tracks the keypad pair state and holds the words the block should return
	class key_entry_scoreboard;
		logic                              keypad_free;
		logic                              second_due;
		logic [kpd2_pkg::KEY_W-1:0]        first_held;
		logic signed [kpd2_pkg::VAL_W-1:0] value_now;
		kpd2_pkg::result_t                 expected_words[$];
		int                                errors;

		function new();
			keypad_free = 1'b1;
			second_due = 1'b0;
			first_held = kpd2_pkg::KEY_NONE;
			value_now = kpd2_pkg::RESET_VALUE;
			errors = 0;
		endfunction

		// key at a scan bit, row-major, three columns per row
		function logic [kpd2_pkg::KEY_W-1:0] pad_key(int bitpos);
			int row;
			int col;
			row = bitpos / 3;
			col = bitpos % 3;
			if (row < 3)
				return kpd2_pkg::KEY_W'(row * 3 + col + 1);
			if (col == 0)
				return kpd2_pkg::KEY_STAR;
			if (col == 1)
				return kpd2_pkg::KEY_W'(0);
			return kpd2_pkg::KEY_HASH;
		endfunction

		function int key_value(logic [kpd2_pkg::KEY_W-1:0] k);
			if (k == kpd2_pkg::KEY_STAR)
				return -6;
			if (k == kpd2_pkg::KEY_HASH)
				return -13;
			if (k <= 4'd9)
				return int'(k);
			return 0;
		endfunction

		task note_word(logic op, logic [kpd2_pkg::RC_W-1:0] rc,
			logic [kpd2_pkg::CN_W-1:0] cn);
			kpd2_pkg::result_t          r;
			logic [kpd2_pkg::KEY_W-1:0] k;
			int                         n;
			n = 0;
			if (op == kpd2_pkg::OP_SCAN) begin
				// every set bit is a press once the keypad was free at the start
				if (keypad_free) begin
					for (int b = 0; b < kpd2_pkg::RC_W; b++) begin
						if (rc[b]) begin
							k = pad_key(b);
							if (second_due) begin
								value_now = kpd2_pkg::VAL_W'(key_value(first_held) * 10 +
									key_value(k));
								first_held = kpd2_pkg::KEY_NONE;
							end else begin
								first_held = k;
							end
							second_due = !second_due;
							keypad_free = 1'b0;
							n++;
						end
					end
				end
			end else if (!keypad_free && cn == '0) begin
				keypad_free = 1'b1;
			end
			r.threshold = value_now;
			r.held = first_held;
			r.awaiting = second_due;
			r.released = keypad_free;
			r.presses = kpd2_pkg::CNT_W'(n);
			expected_words.push_back(r);
		endtask

		task report(string what, int got, int want);
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
			errors++;
		endtask

		task check_word(logic [23:0] data);
			kpd2_pkg::result_t got;
			kpd2_pkg::result_t want;
			got = kpd2_pkg::result_t'(data[18:0]);
			if (expected_words.size() == 0) begin
				report("unexpected word, threshold", int'(got.threshold), 0);
			end else begin
				want = expected_words.pop_front();
				if (got.threshold !== want.threshold)
					report("threshold", int'(got.threshold), int'(want.threshold));
				if (got.held !== want.held)
					report("held_key", int'(got.held), int'(want.held));
				if (got.awaiting !== want.awaiting)
					report("awaiting_second", int'(got.awaiting), int'(want.awaiting));
				if (got.released !== want.released)
					report("released", int'(got.released), int'(want.released));
				if (got.presses !== want.presses)
					report("presses_taken", int'(got.presses), int'(want.presses));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	key_entry_scoreboard sb;
	bit                  steady;
	int unsigned         cycle_count;
	int                  sent;

	keypad_two_digit_entry_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// mostly short gaps, a few long ones, none while steady
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// starts and ends just after a falling edge
	task send_word(logic op, logic [kpd2_pkg::RC_W-1:0] rc, logic [kpd2_pkg::CN_W-1:0] cn);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {1'b0, cn, rc};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_word(op, rc, cn);
		sent++;
		@(negedge clk);
	endtask

	// press a single key, maybe bounce on release, then see it released
	task press_and_release();
		int b;
		b = $urandom_range(0, kpd2_pkg::RC_W - 1);
		send_word(kpd2_pkg::OP_SCAN, kpd2_pkg::RC_W'(1) << b,
			kpd2_pkg::CN_W'($urandom_range(0, 7)));
		if ($urandom_range(0, 4) == 0)
			send_word(kpd2_pkg::OP_RELEASE, kpd2_pkg::RC_W'($urandom),
				kpd2_pkg::CN_W'($urandom_range(1, 7)));
		if ($urandom_range(0, 6) == 0)
			send_word(kpd2_pkg::OP_SCAN, kpd2_pkg::RC_W'($urandom),
				kpd2_pkg::CN_W'($urandom_range(0, 7)));
		send_word(kpd2_pkg::OP_RELEASE, kpd2_pkg::RC_W'($urandom), kpd2_pkg::CN_W'(0));
	endtask

	// output side stalls
	initial begin
		int stall;
		m_tready = 1'b0;
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata);
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int r;
		sb = new();
		steady = 1'b0;
		sent = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = kpd2_pkg::OP_SCAN;
		s_tdata = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: ignored checks and scans, extreme pairs, full keypad scan
		send_word(kpd2_pkg::OP_RELEASE, 12'h000, 3'd0);
		send_word(kpd2_pkg::OP_SCAN, 12'h000, 3'd7);
		send_word(kpd2_pkg::OP_SCAN, 12'h001, 3'd0);
		send_word(kpd2_pkg::OP_SCAN, 12'h010, 3'd0);
		send_word(kpd2_pkg::OP_RELEASE, 12'h000, 3'd7);
		send_word(kpd2_pkg::OP_RELEASE, 12'hfff, 3'd0);
		send_word(kpd2_pkg::OP_SCAN, 12'h800, 3'd0);
		send_word(kpd2_pkg::OP_RELEASE, 12'h000, 3'd0);
		send_word(kpd2_pkg::OP_SCAN, 12'h800, 3'd5);
		send_word(kpd2_pkg::OP_RELEASE, 12'h000, 3'd0);
		send_word(kpd2_pkg::OP_SCAN, 12'h800, 3'd2);
		send_word(kpd2_pkg::OP_RELEASE, 12'h000, 3'd0);
		send_word(kpd2_pkg::OP_SCAN, 12'h200, 3'd0);
		send_word(kpd2_pkg::OP_RELEASE, 12'h555, 3'd0);
		send_word(kpd2_pkg::OP_SCAN, 12'h400, 3'd0);
		send_word(kpd2_pkg::OP_RELEASE, 12'h000, 3'd0);
		send_word(kpd2_pkg::OP_SCAN, 12'h100, 3'd0);
		send_word(kpd2_pkg::OP_RELEASE, 12'haaa, 3'd0);
		send_word(kpd2_pkg::OP_SCAN, 12'h100, 3'd0);
		send_word(kpd2_pkg::OP_RELEASE, 12'h000, 3'd0);
		send_word(kpd2_pkg::OP_SCAN, 12'hfff, 3'd7);
		send_word(kpd2_pkg::OP_SCAN, 12'hfff, 3'd7);
		send_word(kpd2_pkg::OP_RELEASE, 12'h000, 3'd1);
		send_word(kpd2_pkg::OP_RELEASE, 12'hfff, 3'd0);

		while (sent < RANDOM_WORDS + 24) begin
			if ($urandom_range(0, 39) == 0)
				steady = !steady;
			r = $urandom_range(0, 99);
			if (r < 70) begin
				press_and_release();
			end else if (r < 85) begin
				send_word(kpd2_pkg::OP_SCAN, kpd2_pkg::RC_W'($urandom),
					kpd2_pkg::CN_W'($urandom_range(0, 7)));
				send_word(kpd2_pkg::OP_RELEASE, kpd2_pkg::RC_W'($urandom),
					kpd2_pkg::CN_W'(0));
			end else begin
				send_word(($urandom_range(0, 1) == 1) ? kpd2_pkg::OP_RELEASE :
					kpd2_pkg::OP_SCAN, kpd2_pkg::RC_W'($urandom),
					kpd2_pkg::CN_W'($urandom_range(0, 7)));
			end
		end
		s_tvalid <= 1'b0;
		steady = 1'b0;

		while (sb.expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.expected_words.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
